>>> hw/rtl/tpc_pkg.sv
// tpc_pkg: shared constants and blend helpers for the typed pixel compositor
`timescale 1ns / 1ps

package tpc_pkg;

    localparam int PIXEL_W = 32;
    localparam int CHAN_W  = 8;
    localparam int FUNC_W  = 3;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int RGB_W   = 24;

    // pixel kind codes in the low byte
    localparam logic [CHAN_W-1:0] KIND_EMPTY  = 8'h00;
    localparam logic [CHAN_W-1:0] KIND_TILE   = 8'hFF;
    localparam logic [CHAN_W-1:0] KIND_OBJECT = 8'hE0;

    // drawing modes
    localparam logic [FUNC_W-1:0] FUNC_BG_TILE    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ERASE      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TILE       = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_OBJ_ON_TILE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_OBJ_ON_BG  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_OBJ_ANY    = 3'd5;
    // unused codes, nothing is drawn
    localparam logic [FUNC_W-1:0] FUNC_RSVD_LO    = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_HI    = 3'd7;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_TILE_ALPHA  = 2'd0;
    localparam logic [1:0] REG_OBJ_ALPHA   = 2'd1;
    localparam logic [1:0] REG_ERASE_ALPHA = 2'd2;
    localparam logic [1:0] REG_ERASE_RGB   = 2'd3;

    // (e*(255-a) + i*a) / 255, truncated
    function automatic logic [CHAN_W-1:0] mix_channel(
        input logic [CHAN_W-1:0] e,
        input logic [CHAN_W-1:0] i,
        input logic [CHAN_W-1:0] a
    );
        logic [15:0] prod_e;
        logic [15:0] prod_i;
        logic [16:0] sum;
        logic [16:0] adj;
        prod_e = {8'd0, e} * {8'd0, ~a};
        prod_i = {8'd0, i} * {8'd0, a};
        sum    = {1'b0, prod_e} + {1'b0, prod_i};
        // divide by 255: exact for sums below 65535
        adj    = sum + 17'd1 + {8'd0, sum[16:8]};
        return adj[15:8];
    endfunction

    function automatic logic [PIXEL_W-1:0] blend_word(
        input logic [PIXEL_W-1:0] ext,
        input logic [PIXEL_W-1:0] inc,
        input logic [CHAN_W-1:0]  a,
        input logic [CHAN_W-1:0]  kind
    );
        return {mix_channel(ext[31:24], inc[31:24], a),
                mix_channel(ext[23:16], inc[23:16], a),
                mix_channel(ext[15:8],  inc[15:8],  a),
                kind};
    endfunction

endpackage

>>> hw/rtl/typed_pixel_compositor.sv
// typed_pixel_compositor: top level, register file and blend pipeline
`timescale 1ns / 1ps

// Takes one item per cycle: busy stays low, so an item is accepted on every
// cycle that start is high. Each item gives one result on out_pixel and
// drawn, marked by a one-cycle done strobe; each item passes the input
// register, then one blend stage into the result register.
// The result cannot be held off; the receiver must take it in that cycle.
// Registers at byte addresses 0 tile weight, 4 object weight,
// 8 eraser weight, C eraser color; write them only while no item is in flight.

module typed_pixel_compositor
    import tpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // item channel
    input  logic               start,
    output logic               busy,
    input  logic [FUNC_W-1:0]  func,
    input  logic [PIXEL_W-1:0] dest_pixel,
    input  logic [PIXEL_W-1:0] src_pixel,
    output logic               done,
    output logic [PIXEL_W-1:0] out_pixel,
    output logic               drawn,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [CHAN_W-1:0] tile_alpha_reg;
    logic [CHAN_W-1:0] obj_alpha_reg;
    logic [CHAN_W-1:0] erase_alpha_reg;
    logic [RGB_W-1:0]  erase_rgb_reg;

    logic               in_valid_reg;
    logic [FUNC_W-1:0]  func_reg;
    logic [PIXEL_W-1:0] dest_reg;
    logic [PIXEL_W-1:0] src_reg;

    logic               done_reg;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic               drawn_reg;

    logic               cfg_write;
    logic [PIXEL_W-1:0] out_pixel_next;
    logic               drawn_next;
    logic [PIXEL_W-1:0] ext_sel;
    logic [PIXEL_W-1:0] inc_sel;
    logic [CHAN_W-1:0]  weight_sel;
    logic [CHAN_W-1:0]  kind_sel;
    logic               opaque;
    logic [CHAN_W-1:0]  dkind;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_alpha_reg  <= 8'hFF;
            obj_alpha_reg   <= 8'hFF;
            erase_alpha_reg <= 8'hFF;
            erase_rgb_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_TILE_ALPHA:  tile_alpha_reg  <= pwdata[CHAN_W-1:0];
                REG_OBJ_ALPHA:   obj_alpha_reg   <= pwdata[CHAN_W-1:0];
                REG_ERASE_ALPHA: erase_alpha_reg <= pwdata[CHAN_W-1:0];
                REG_ERASE_RGB:   erase_rgb_reg   <= pwdata[RGB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TILE_ALPHA:  prdata = {24'd0, tile_alpha_reg};
            REG_OBJ_ALPHA:   prdata = {24'd0, obj_alpha_reg};
            REG_ERASE_ALPHA: prdata = {24'd0, erase_alpha_reg};
            REG_ERASE_RGB:   prdata = {8'd0, erase_rgb_reg};
            default:         prdata = '0;
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            func_reg <= func;
            dest_reg <= dest_pixel;
            src_reg  <= src_pixel;
        end
    end

    // mode decode and blend
    assign opaque = (src_reg[7:0] != 8'h00);
    assign dkind  = dest_reg[7:0];

    always_comb
    begin
        ext_sel    = dest_reg;
        inc_sel    = src_reg;
        weight_sel = obj_alpha_reg;
        kind_sel   = KIND_OBJECT;
        drawn_next = 1'b0;
        unique case (func_reg)
            FUNC_BG_TILE:
            begin
                ext_sel    = '0;
                weight_sel = tile_alpha_reg;
                kind_sel   = src_reg[7:0];
                drawn_next = opaque && (dkind == KIND_EMPTY);
            end
            FUNC_ERASE:
            begin
                inc_sel    = {erase_rgb_reg, 8'h00};
                weight_sel = erase_alpha_reg;
                kind_sel   = KIND_EMPTY;
                drawn_next = opaque;
            end
            FUNC_TILE:
            begin
                weight_sel = tile_alpha_reg;
                kind_sel   = KIND_TILE;
                drawn_next = opaque;
            end
            FUNC_OBJ_ON_TILE: drawn_next = opaque && (dkind == KIND_TILE);
            FUNC_OBJ_ON_BG:   drawn_next = opaque && (dkind == KIND_EMPTY);
            FUNC_OBJ_ANY:     drawn_next = opaque;
            default:          drawn_next = 1'b0;
        endcase
        out_pixel_next = drawn_next ? blend_word(ext_sel, inc_sel, weight_sel, kind_sel)
                                    : dest_reg;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            out_pixel_reg <= out_pixel_next;
            drawn_reg     <= drawn_next;
        end
    end

    assign done      = done_reg;
    assign out_pixel = out_pixel_reg;
    assign drawn     = drawn_reg;

endmodule
